// File: rtl/dlbp_pkg.sv
// Package for the definite-length block parser.
// Holds register indexes, field widths, parse phases and the shared structs.
// No dependencies.
package dlbp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 27;
  localparam int unsigned RecLenW = 27;
  localparam int unsigned BppW    = 2;
  localparam int unsigned RecCntW = 7;
  localparam int unsigned AccW    = 35;
  localparam int unsigned WantW   = RecLenW + BppW + RecCntW;
  localparam int unsigned DigW    = 4;

  localparam logic [ByteW-1:0] HashChar  = 8'h23;
  localparam logic [DigW-1:0]  MaxDigits = 4'd15;

  localparam logic [CfgIdxW-1:0] RegListen  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRecLen  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBpp     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMulti   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRecCnt  = 3'd4;

  typedef enum logic [3:0] {
    PhHunt    = 4'b0001,
    PhCount   = 4'b0010,
    PhDigits  = 4'b0100,
    PhPayload = 4'b1000
  } phase_e;

  typedef struct packed {
    logic             listen;
    logic             clear;
    logic [WantW-1:0] want;
  } dlbp_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             last;
  } dlbp_res_t;

  // Bit 4 flags a hex digit of either case, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// File: rtl/definite_length_block_parser.sv
// Channel | Handshake              | Word
// --------+------------------------+--------------------------------------
// in      | in_valid_i / in_stall_o | rx_byte_i
// out     | out_valid_o / out_stall_i | payload_byte_o, last_of_block_o
// cfg     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One word is taken every cycle while in_stall_o is low; a payload word passes
// through the input register, then the result register, before it leaves.
// Nothing else is produced for header or dropped words.
// in_stall_o rises only while the result register is full and stalled and the
// input register holds a word. Reset is asynchronous and clears all control.
// Top level of the definite-length block parser; depends on dlbp_pkg,
// dlbp_cfg_regs and dlbp_parser.
module definite_length_block_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dlbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dlbp_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dlbp_pkg::ByteW-1:0]     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dlbp_pkg::ByteW-1:0]     payload_byte_o,
  output logic                           last_of_block_o
);
  import dlbp_pkg::*;

  dlbp_cfg_t        cfg;
  dlbp_res_t        res;
  logic             stage_valid_q, stage_valid_d;
  logic [ByteW-1:0] stage_byte_q;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;
  logic             advance;
  logic             fire;

  dlbp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dlbp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .byte_i (stage_byte_q),
    .res_o  (res)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = stage_valid_q && advance;
  assign in_stall_o = stage_valid_q && !advance;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (!in_stall_o) stage_valid_d = in_valid_i;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = fire && res.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) stage_byte_q <= rx_byte_i;
    if (fire && res.valid) begin
      out_byte_q <= res.data;
      out_last_q <= res.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_byte_q;
  assign last_of_block_o = out_last_q;

endmodule

// File: rtl/dlbp_cfg_regs.sv
// Configuration registers of the block parser and the registered expected
// block size. Depends on dlbp_pkg.
module dlbp_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dlbp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dlbp_pkg::CfgW-1:0]       cfg_wdata_i,
  output dlbp_pkg::dlbp_cfg_t             cfg_o
);
  import dlbp_pkg::*;

  logic               listen_q;
  logic [RecLenW-1:0] rec_len_q;
  logic [BppW-1:0]    bpp_q;
  logic               multi_q;
  logic [RecCntW-1:0] rec_cnt_q;
  logic [WantW-1:0]   want_q, want_d;
  logic [RecCntW-1:0] frames;
  logic [BppW+RecCntW-1:0] bpp_frames;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q  <= 1'b0;
      rec_len_q <= RecLenW'(1);
      bpp_q     <= BppW'(1);
      multi_q   <= 1'b0;
      rec_cnt_q <= RecCntW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegListen: listen_q  <= cfg_wdata_i[0];
        RegRecLen: rec_len_q <= cfg_wdata_i[RecLenW-1:0];
        RegBpp:    bpp_q     <= cfg_wdata_i[BppW-1:0];
        RegMulti:  multi_q   <= cfg_wdata_i[0];
        RegRecCnt: rec_cnt_q <= cfg_wdata_i[RecCntW-1:0];
        default: ;
      endcase
    end
  end

  assign frames     = multi_q ? rec_cnt_q : RecCntW'(1);
  assign bpp_frames = (BppW+RecCntW)'(bpp_q) * (BppW+RecCntW)'(frames);
  assign want_d     = WantW'(rec_len_q) * WantW'(bpp_frames);

  // The product is registered from the configuration registers; blocks need several bytes
  // before the size check, so the delay is never visible.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_q <= WantW'(1);
    end else begin
      want_q <= want_d;
    end
  end

  assign cfg_o.listen = listen_q;
  assign cfg_o.clear  = cfg_we_i && (cfg_idx_i == RegListen);
  assign cfg_o.want   = want_q;

endmodule

// File: rtl/dlbp_parser.sv
// Parse state and per-byte step logic of the block parser.
// Depends on dlbp_pkg.
module dlbp_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dlbp_pkg::dlbp_cfg_t         cfg_i,
  input  logic                        fire_i,
  input  logic [dlbp_pkg::ByteW-1:0]  byte_i,
  output dlbp_pkg::dlbp_res_t         res_o
);
  import dlbp_pkg::*;

  phase_e          phase_q, phase_d;
  logic [DigW-1:0] digits_q, digits_d;
  logic [AccW-1:0] accum_q, accum_d;
  logic            ovf_q, ovf_d;
  logic [AccW-1:0] left_q, left_d;

  logic [4:0]      hex;
  logic [AccW+3:0] acc_next;
  logic [DigW-1:0] digits_dec;
  logic [AccW-1:0] left_dec;
  logic            is_dec;
  logic            ovf_now;

  assign hex        = hex_digit(byte_i);
  assign is_dec     = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign acc_next   = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1)
                    + (AccW+4)'(byte_i[3:0]);
  assign digits_dec = digits_q - DigW'(1);
  assign left_dec   = left_q - AccW'(1);
  assign ovf_now    = ovf_q || !is_dec || (acc_next[AccW+3:AccW] != 4'd0);

  always_comb begin
    phase_d   = phase_q;
    digits_d  = digits_q;
    accum_d   = accum_q;
    ovf_d     = ovf_q;
    left_d    = left_q;
    res_o.valid = 1'b0;
    res_o.data  = byte_i;
    res_o.last  = 1'b0;

    if (fire_i && cfg_i.listen) begin
      unique case (phase_q)
        PhHunt: begin
          if (byte_i == HashChar) phase_d = PhCount;
        end
        PhCount: begin
          if (!hex[4] || hex[3:0] == 4'd0 || hex[3:0] > MaxDigits) begin
            phase_d = PhHunt;
            digits_d = '0;
            accum_d  = '0;
            ovf_d    = 1'b0;
            left_d   = '0;
          end else begin
            digits_d = hex[3:0];
            accum_d  = '0;
            ovf_d    = 1'b0;
            phase_d  = PhDigits;
          end
        end
        PhDigits: begin
          ovf_d    = ovf_now;
          if (!ovf_now) accum_d = acc_next[AccW-1:0];
          digits_d = digits_dec;
          if (digits_dec == '0) begin
            // Reject on a bad or overflowed count, an empty block, or a size
            // that differs from the configured one.
            if (ovf_now || cfg_i.want == '0 ||
                {1'b0, accum_d} != (AccW+1)'(cfg_i.want)) begin
              phase_d  = PhHunt;
              digits_d = '0;
              accum_d  = '0;
              ovf_d    = 1'b0;
              left_d   = '0;
            end else begin
              left_d  = accum_d;
              phase_d = PhPayload;
            end
          end
        end
        PhPayload: begin
          res_o.valid = 1'b1;
          left_d      = left_dec;
          if (left_dec == '0) begin
            res_o.last = 1'b1;
            phase_d    = PhHunt;
            digits_d   = '0;
            accum_d    = '0;
            ovf_d      = 1'b0;
          end
        end
        default: begin
          phase_d  = PhHunt;
          digits_d = '0;
          accum_d  = '0;
          ovf_d    = 1'b0;
          left_d   = '0;
        end
      endcase
    end

    if (cfg_i.clear) begin
      phase_d  = PhHunt;
      digits_d = '0;
      accum_d  = '0;
      ovf_d    = 1'b0;
      left_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      digits_q <= '0;
      accum_q  <= '0;
      ovf_q    <= 1'b0;
      left_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      digits_q <= digits_d;
      accum_q  <= accum_d;
      ovf_q    <= ovf_d;
      left_q   <= left_d;
    end
  end

endmodule

// File: rtl/dlbp_checker.sv
// Port-level checker for the block parser, bound to the top level.
// Depends on dlbp_pkg.
module dlbp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [dlbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input logic [dlbp_pkg::CfgW-1:0]      cfg_wdata_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [dlbp_pkg::ByteW-1:0]     payload_byte_o,
  input logic                           last_of_block_o
);
  import dlbp_pkg::*;

  logic off_q;

  // Tracks whether listening is switched off, as seen on the write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= 1'b1;
    end else if (cfg_we_i && cfg_idx_i == RegListen) begin
      off_q <= !cfg_wdata_i[0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(payload_byte_o) && $stable(last_of_block_o))
    else $error("stalled result word changed");

  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result word without an accepted word two cycles before");

  a_listen_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q && $past(off_q) |-> !$rose(out_valid_o))
    else $error("result word produced while listening is off");

endmodule

bind definite_length_block_parser dlbp_checker u_dlbp_checker (.*);
